// ----- rtl/mmg_pkg.sv -----
// ----------------------------------------------------------------------------
// mmg_pkg: shared types and constants for the multiscale morphological gradient
// Pixel and tag types, register indexes, geometry limits, rounding constants and max3/min3.
// ----------------------------------------------------------------------------
package mmg_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int CFG_W         = 13;
    localparam int IDX_W         = 2;
    localparam int MIN_SIDE      = 8;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RESET_SIDE    = 1024;
    // stream row counter runs up to the frame height plus five flush rows
    localparam int ROW_W         = FH_W;
    localparam int SUM_W         = 10;
    // floor(s * 683 / 2048) equals floor(s / 3) for every s below 2047
    localparam int RECIP3        = 683;
    localparam int RECIP_SH      = 11;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;

    // per-item masks and flags that travel down the pipeline
    typedef struct packed {
        logic m3;    // 3x3 interior at the output center (G3 and G5e)
        logic m5;    // 5x5 interior at the G5 center
        logic m7;    // 7x7 interior at the G7 center
        logic m7e;   // 5x5 interior at the output center (G7e)
        logic emit;  // output center lies in the frame
        logic last;  // output center is the final frame position
    } mmg_tag_t;

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

// ----- rtl/mmg_pix_if.sv -----
// ----------------------------------------------------------------------------
// mmg_pix_if: input pixel channel
// Valid/ready stream of raster pixels with a filler flag.
// ----------------------------------------------------------------------------
interface mmg_pix_if;
    logic          valid;
    logic          ready;
    mmg_pkg::pix_t pixel;
    logic          pad;

    modport source (output valid, output pixel, output pad, input ready);
    modport sink   (input valid, input pixel, input pad, output ready);
endinterface

// ----- rtl/mmg_res_if.sv -----
// ----------------------------------------------------------------------------
// mmg_res_if: result channel
// Valid/ready stream of gradient values with an end-of-frame flag.
// ----------------------------------------------------------------------------
interface mmg_res_if;
    logic          valid;
    logic          ready;
    mmg_pkg::pix_t value;
    logic          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/mmg_line_buf.sv -----
// ----------------------------------------------------------------------------
// mmg_line_buf: line buffer memory
// One port writes a packed column of taps, the other fetches the next column
// ahead of use; read data is registered.
// ----------------------------------------------------------------------------
module mmg_line_buf #(
    parameter int DEPTH  = mmg_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = mmg_pkg::PIX_W
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[wr_addr] <= wr_data;
            rd_data_reg  <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- rtl/multiscale_morph_gradient_core.sv -----
// ----------------------------------------------------------------------------
// multiscale_morph_gradient_core: multiscale morphological gradient
// Streams 8-bit raster pixels and returns (G3 + G5e + G7e + 1) / 3 per pixel.
// ----------------------------------------------------------------------------
// The core takes one pixel request per clock and returns one gradient per
// clock. The result for frame position p leaves after the request with frame
// index p + 5*W + 5 is taken (fillers count), through a 7x7 input window fed
// by a six-line buffer, row then column max/min stages, two- and four-line
// gradient buffers with 3x3 and 5x5 erosion windows, a min stage, a sum and
// a multiply by the reciprocal of three. Each line buffer is one memory whose
// next column is fetched as the current one is written, so the sustained rate
// is one request per cycle whenever results are taken. Fillers in the middle
// of a frame are dropped; after the frame's pixels they flush the lag.
// A width or height write restarts the frame. There is no clearing pass after
// reset: memory entries are only used once written in the frame.
module multiscale_morph_gradient_core #(
    parameter int MAX_WIDTH = mmg_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mmg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mmg_pkg::CFG_W-1:0]   cfg_data,
    mmg_pix_if.sink                     pixels,
    mmg_res_if.source                   results
);
    import mmg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SW = ROW_W + 1;
    localparam logic [WW-1:0] W_RESET =
        WW'((RESET_SIDE < MAX_WIDTH) ? RESET_SIDE : MAX_WIDTH);

    function automatic logic [WW-1:0] clamp_w(input logic [FW_W-1:0] fw);
        logic [WW-1:0] r;
        if (32'(fw) < MIN_SIDE)
            r = WW'(MIN_SIDE);
        else if (32'(fw) > MAX_WIDTH)
            r = WW'(MAX_WIDTH);
        else
            r = WW'(fw);
        return r;
    endfunction

    function automatic logic [FH_W-1:0] clamp_h(input logic [CFG_W-1:0] fh);
        logic [FH_W-1:0] r;
        if (32'(fh) < MIN_SIDE)
            r = FH_W'(MIN_SIDE);
        else if (32'(fh) > MAX_HEIGHT)
            r = FH_W'(MAX_HEIGHT);
        else
            r = FH_W'(fh);
        return r;
    endfunction

    // column of the position k rows and k columns behind the stream head
    function automatic logic [CW-1:0] ctr_col(input logic [CW-1:0] c,
                                              input logic [WW-1:0] w, input int k);
        logic [WW-1:0] t;
        if (32'(c) >= k)
            t = WW'(c) - WW'(k);
        else
            t = WW'(c) + w - WW'(k);
        return t[CW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] ctr_row(input logic [ROW_W-1:0] r,
                                                     input logic [CW-1:0] c,
                                                     input int k);
        logic signed [SW-1:0] t;
        t = $signed({1'b0, r}) - $signed(SW'(k));
        if (32'(c) < k)
            t = t - $signed(SW'(1));
        return t;
    endfunction

    function automatic logic in_core(input logic signed [SW-1:0] row,
                                     input logic [CW-1:0] col,
                                     input logic [WW-1:0] w,
                                     input logic [FH_W-1:0] h, input int g);
        logic signed [SW-1:0] row_hi;
        logic [WW:0]          col_end;
        row_hi  = $signed({1'b0, h}) - $signed(SW'(g + 1));
        col_end = (WW+1)'(col) + (WW+1)'(g + 1);
        return (row >= $signed(SW'(g))) && (row <= row_hi) &&
               (32'(col) >= g) && (col_end <= {1'b0, w});
    endfunction

    // ---------------------------------------------------------------- config
    logic [WW-1:0]   w_reg;
    logic [FH_W-1:0] h_reg;
    logic            cfg_restart;

    assign cfg_restart = cfg_wr_en &&
        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_RESET;
            h_reg <= FH_W'(RESET_SIDE);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  w_reg <= clamp_w(cfg_data[FW_W-1:0]);
                REG_FRAME_HEIGHT: h_reg <= clamp_h(cfg_data);
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------ handshake
    logic adv, acc, drop, push;
    logic out_valid_reg, out_last_reg;
    pix_t out_value_reg;

    assign adv           = !out_valid_reg || results.ready;
    assign pixels.ready  = adv;
    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;
    assign results.last  = out_last_reg;

    // --------------------------------------------------- stream position
    logic [CW-1:0]        cn_reg, cn_next;
    logic [ROW_W-1:0]     rn_reg, rn_next;
    logic [WW-1:0]        cn_inc;
    logic signed [SW-1:0] row3c, row4c, row5c;
    logic [CW-1:0]        col3c, col4c, col5c;
    mmg_tag_t             tag_s0;

    assign acc  = pixels.valid && adv;
    assign drop = pixels.pad && (rn_reg < h_reg);
    assign push = acc && !drop;

    always_comb
    begin
        row3c = ctr_row(rn_reg, cn_reg, 3);
        row4c = ctr_row(rn_reg, cn_reg, 4);
        row5c = ctr_row(rn_reg, cn_reg, 5);
        col3c = ctr_col(cn_reg, w_reg, 3);
        col4c = ctr_col(cn_reg, w_reg, 4);
        col5c = ctr_col(cn_reg, w_reg, 5);
        tag_s0.m7   = in_core(row3c, col3c, w_reg, h_reg, 3);
        tag_s0.m5   = in_core(row4c, col4c, w_reg, h_reg, 2);
        tag_s0.m3   = in_core(row5c, col5c, w_reg, h_reg, 1);
        tag_s0.m7e  = in_core(row5c, col5c, w_reg, h_reg, 2);
        tag_s0.emit = !row5c[SW-1];
        tag_s0.last = (row5c == $signed({1'b0, h_reg - FH_W'(1)})) &&
                      (WW'(col5c) == w_reg - WW'(1));

        cn_inc  = WW'(cn_reg) + WW'(1);
        cn_next = cn_inc[CW-1:0];
        rn_next = rn_reg;
        if (tag_s0.last)
        begin
            // frame done: the next request starts a new frame
            cn_next = '0;
            rn_next = '0;
        end
        else if (cn_inc == w_reg)
        begin
            cn_next = '0;
            rn_next = rn_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cn_reg <= '0;
            rn_reg <= '0;
        end
        else if (cfg_restart)
        begin
            cn_reg <= '0;
            rn_reg <= '0;
        end
        else if (push)
        begin
            cn_reg <= cn_next;
            rn_reg <= rn_next;
        end
    end

    // ------------------------------------------------ input lines and window
    logic [6*PIX_W-1:0] in_rd;
    pix_t               tap [7];
    pix_t               win_reg [7][7];

    mmg_line_buf #(.DEPTH(MAX_WIDTH), .DATA_W(6*PIX_W)) u_in_buf (
        .clk     (clk),
        .en      (push),
        .wr_addr (cn_reg),
        .wr_data ({in_rd[5*PIX_W-1:0], pixels.pixel}),
        .rd_addr (cn_next),
        .rd_data (in_rd)
    );

    always_comb
    begin
        tap[0] = pixels.pixel;
        for (int k = 1; k < 7; k++)
            tap[k] = in_rd[PIX_W*(k-1) +: PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = 0; k < 7; k++)
            begin
                win_reg[k][0] <= tap[k];
                for (int j = 1; j < 7; j++)
                    win_reg[k][j] <= win_reg[k][j-1];
            end
        end
    end

    // ---------------------------------------------------- pipeline control
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    mmg_tag_t      tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [CW-1:0] col1_reg, col2_reg, col3_reg;
    logic          emit6_reg, last6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= push;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg && emit6_reg;
        end
    end

    // stage 1: tag for the window just loaded
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tag1_reg <= tag_s0;
            col1_reg <= cn_reg;
        end
    end

    // stage 2: per-row max/min over the right 3, 5 and 7 columns
    pix_t mx3 [7], mx5 [7], mx7 [7], mn3 [7], mn5 [7], mn7 [7];
    pix_t rmx3_reg [7], rmx5_reg [7], rmx7_reg [7];
    pix_t rmn3_reg [7], rmn5_reg [7], rmn7_reg [7];

    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            mx3[k] = max3(win_reg[k][4], win_reg[k][5], win_reg[k][6]);
            mn3[k] = min3(win_reg[k][4], win_reg[k][5], win_reg[k][6]);
            mx5[k] = max3(mx3[k], win_reg[k][2], win_reg[k][3]);
            mn5[k] = min3(mn3[k], win_reg[k][2], win_reg[k][3]);
            mx7[k] = max3(mx5[k], win_reg[k][0], win_reg[k][1]);
            mn7[k] = min3(mn5[k], win_reg[k][0], win_reg[k][1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v1_reg)
        begin
            tag2_reg <= tag1_reg;
            col2_reg <= col1_reg;
            rmx3_reg <= mx3;
            rmx5_reg <= mx5;
            rmx7_reg <= mx7;
            rmn3_reg <= mn3;
            rmn5_reg <= mn5;
            rmn7_reg <= mn7;
        end
    end

    // stage 3: combine rows into the three ranges and mask
    pix_t hi3, lo3, hi5, lo5, hi7, lo7;
    pix_t g3_3_reg, g5_3_reg, g7_3_reg;

    always_comb
    begin
        hi3 = max3(rmx3_reg[4], rmx3_reg[5], rmx3_reg[6]);
        lo3 = min3(rmn3_reg[4], rmn3_reg[5], rmn3_reg[6]);
        hi5 = rmx5_reg[2];
        lo5 = rmn5_reg[2];
        for (int k = 3; k < 7; k++)
        begin
            hi5 = (rmx5_reg[k] > hi5) ? rmx5_reg[k] : hi5;
            lo5 = (rmn5_reg[k] < lo5) ? rmn5_reg[k] : lo5;
        end
        hi7 = rmx7_reg[0];
        lo7 = rmn7_reg[0];
        for (int k = 1; k < 7; k++)
        begin
            hi7 = (rmx7_reg[k] > hi7) ? rmx7_reg[k] : hi7;
            lo7 = (rmn7_reg[k] < lo7) ? rmn7_reg[k] : lo7;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg)
        begin
            tag3_reg <= tag2_reg;
            col3_reg <= col2_reg;
            g3_3_reg <= tag2_reg.m3 ? pix_t'(hi3 - lo3) : '0;
            g5_3_reg <= tag2_reg.m5 ? pix_t'(hi5 - lo5) : '0;
            g7_3_reg <= tag2_reg.m7 ? pix_t'(hi7 - lo7) : '0;
        end
    end

    // stage 4: gradient line buffers and erosion windows
    logic               gpush;
    logic [WW-1:0]      gcol_inc;
    logic [CW-1:0]      gcol_next;
    logic [2*PIX_W-1:0] g5_rd;
    logic [4*PIX_W-1:0] g7_rd;
    pix_t               g5_tap [3];
    pix_t               g7_tap [5];
    pix_t               w5_reg [3][3];
    pix_t               w7_reg [5][5];
    pix_t               g3_4_reg;

    assign gpush = adv && v3_reg;

    always_comb
    begin
        gcol_inc  = WW'(col3_reg) + WW'(1);
        gcol_next = gcol_inc[CW-1:0];
        if (tag3_reg.last || gcol_inc == w_reg)
            gcol_next = '0;
        g5_tap[0] = g5_3_reg;
        for (int k = 1; k < 3; k++)
            g5_tap[k] = g5_rd[PIX_W*(k-1) +: PIX_W];
        g7_tap[0] = g7_3_reg;
        for (int k = 1; k < 5; k++)
            g7_tap[k] = g7_rd[PIX_W*(k-1) +: PIX_W];
    end

    mmg_line_buf #(.DEPTH(MAX_WIDTH), .DATA_W(2*PIX_W)) u_g5_buf (
        .clk     (clk),
        .en      (gpush),
        .wr_addr (col3_reg),
        .wr_data ({g5_rd[PIX_W-1:0], g5_3_reg}),
        .rd_addr (gcol_next),
        .rd_data (g5_rd)
    );

    mmg_line_buf #(.DEPTH(MAX_WIDTH), .DATA_W(4*PIX_W)) u_g7_buf (
        .clk     (clk),
        .en      (gpush),
        .wr_addr (col3_reg),
        .wr_data ({g7_rd[3*PIX_W-1:0], g7_3_reg}),
        .rd_addr (gcol_next),
        .rd_data (g7_rd)
    );

    always_ff @(posedge clk)
    begin
        if (gpush)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w5_reg[k][0] <= g5_tap[k];
                for (int j = 1; j < 3; j++)
                    w5_reg[k][j] <= w5_reg[k][j-1];
            end
            for (int k = 0; k < 5; k++)
            begin
                w7_reg[k][0] <= g7_tap[k];
                for (int j = 1; j < 5; j++)
                    w7_reg[k][j] <= w7_reg[k][j-1];
            end
            tag4_reg <= tag3_reg;
            g3_4_reg <= g3_3_reg;
        end
    end

    // stage 5: row minimums of both erosion windows
    pix_t r5min [3];
    pix_t r7min [5];
    pix_t r5_reg [3];
    pix_t r7_reg [5];
    pix_t g3_5_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            r5min[k] = min3(w5_reg[k][0], w5_reg[k][1], w5_reg[k][2]);
        for (int k = 0; k < 5; k++)
        begin
            r7min[k] = min3(w7_reg[k][0], w7_reg[k][1], w7_reg[k][2]);
            r7min[k] = min3(r7min[k], w7_reg[k][3], w7_reg[k][4]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v4_reg)
        begin
            r5_reg   <= r5min;
            r7_reg   <= r7min;
            tag5_reg <= tag4_reg;
            g3_5_reg <= g3_4_reg;
        end
    end

    // stage 6: finish erosion, mask and add with rounding
    pix_t             e5, e7, g5e, g7e;
    logic [SUM_W-1:0] sum6_reg;

    always_comb
    begin
        e5 = min3(r5_reg[0], r5_reg[1], r5_reg[2]);
        e7 = min3(r7_reg[0], r7_reg[1], r7_reg[2]);
        e7 = min3(e7, r7_reg[3], r7_reg[4]);
        g5e = tag5_reg.m3  ? e5 : '0;
        g7e = tag5_reg.m7e ? e7 : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v5_reg)
        begin
            sum6_reg  <= SUM_W'(g3_5_reg) + SUM_W'(g5e) + SUM_W'(g7e) + SUM_W'(1);
            emit6_reg <= tag5_reg.emit;
            last6_reg <= tag5_reg.last;
        end
    end

    // stage 7: divide by three through the reciprocal
    logic [2*SUM_W-1:0] prod;

    assign prod = (2*SUM_W)'(sum6_reg) * (2*SUM_W)'(RECIP3);

    always_ff @(posedge clk)
    begin
        if (adv && v6_reg && emit6_reg)
        begin
            out_value_reg <= prod[RECIP_SH +: PIX_W];
            out_last_reg  <= last6_reg;
        end
    end

    // ----------------------------------------------------------- assertions
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(cn_reg) < w_reg)
        else $error("stream column ran past the frame width");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && tag_s0.last && !cfg_restart) |=> (cn_reg == '0 && rn_reg == '0))
        else $error("position counters did not restart after the final result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg}))
        else $error("pipeline moved while the result was stalled");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && last6_reg) |-> emit6_reg)
        else $error("final-position flag on an item with no result");

endmodule
